// ===== src/deadline_sorted_task_queue_top_macros.svh =====
// assertion helpers for the deadline sorted task queue
`ifndef DEADLINE_SORTED_TASK_QUEUE_TOP_MACROS_SVH
`define DEADLINE_SORTED_TASK_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DSTQ_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("dstq assertion failed");
// next-cycle implication
`define DSTQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("dstq assertion failed");
`else
`define DSTQ_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`define DSTQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== src/dstq_pkg.sv =====
`timescale 1ns / 1ps
package dstq_pkg;

  localparam int DL_W        = 64;
  localparam int TID_W       = 6;
  localparam int CNT_OUT_W   = 5;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_POLL   = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  // one queue slot
  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [TID_W-1:0] task_id;
  } entry_t;

  // per-request control broadcast to every cell
  typedef struct packed {
    logic do_insert;
    logic do_remove;
    logic do_pop;
  } cell_ctl_t;

endpackage

// ===== src/dstq_cell.sv =====
`timescale 1ns / 1ps
module dstq_cell (
  input  logic               clk,
  input  dstq_pkg::cell_ctl_t ctl,
  input  dstq_pkg::entry_t   new_entry,
  input  logic               valid,
  input  dstq_pkg::entry_t   left_q,
  input  dstq_pkg::entry_t   right_q,
  input  logic               left_le,
  input  logic               left_hit,
  output dstq_pkg::entry_t   q,
  output dstq_pkg::entry_t   q_nxt,
  output logic               le,
  output logic               hit
);
  import dstq_pkg::*;

  entry_t q_r;
  logic   shift_left;

  // slot stays put on insert when its deadline is not later than the new one
  assign le   = valid && (q_r.deadline <= new_entry.deadline);
  // running "removed slot is at or left of here" flag
  assign hit  = left_hit || (valid && (q_r.task_id == new_entry.task_id));
  assign shift_left = ctl.do_pop || (ctl.do_remove && hit);

  always_comb begin
    q_nxt = q_r;
    if (ctl.do_insert) begin
      if (!le) begin
        if (left_le) begin
          q_nxt = new_entry;
        end else begin
          q_nxt = left_q;
        end
      end
    end else if (shift_left) begin
      q_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== src/deadline_sorted_task_queue_top.sv =====
`timescale 1ns / 1ps
// Deadline sorted task queue: holds up to QUEUE_DEPTH task ids in ascending
// deadline order (equal deadlines keep arrival order) in a row of cells, one
// slot per cell. A request is taken on in_tvalid & in_tready and carries the
// mode in in_tuser (insert, poll, remove). Every request is finished in the
// cycle it is accepted: each cell compares its own deadline and task id
// against the request and either holds, loads the new entry or takes its
// neighbor's slot, so the row shifts right on insert and left on pop or
// remove. One result per request is registered in the output register, and
// a new request is taken every cycle as long as that register
// is empty or being drained, so the sustained rate is one request per clock;
// only a stalled out_tready holds the input back. Results report success,
// the popped task, the full flag, and the head deadline and entry count after
// the request. Inserting a task already queued, or any task id at or beyond
// TASK_COUNT, is refused without a full flag. No clearing pass is needed
// after reset: the queue is empty as soon as rst_n is released.
`include "deadline_sorted_task_queue_top_macros.svh"
module deadline_sorted_task_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_COUNT  = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // task_id [5:0], deadline [69:6], now_time [133:70], zero pad [135:134]
  input  logic [dstq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // mode [1:0]
  input  logic [dstq_pkg::MODE_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // popped_task [5:0], head_deadline [69:6], entry_count [74:70], zero pad [79:75]
  output logic [dstq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // success [0], queue_full [1], head_valid [2]
  output logic [dstq_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import dstq_pkg::*;

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int MARK_IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  // request fields
  logic [TID_W-1:0] req_id;
  logic [DL_W-1:0]  req_deadline;
  logic [DL_W-1:0]  req_now;
  logic             req_accept;

  // queue state
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TASK_COUNT-1:0] marks_r, marks_nxt;

  // cell row wiring
  entry_t    new_entry;
  cell_ctl_t ctl;
  entry_t    cell_q     [QUEUE_DEPTH];
  entry_t    cell_q_nxt [QUEUE_DEPTH];
  logic      cell_le    [QUEUE_DEPTH];
  logic      cell_hit   [QUEUE_DEPTH];

  // decode
  logic id_in_range, id_marked, is_full, head_due;
  logic ins_ok, ins_full, pop_ok, rem_ok;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              success_r, success_nxt;
  logic              full_r, full_nxt;
  logic              head_valid_r, head_valid_nxt;
  logic [TID_W-1:0]  popped_r, popped_nxt;
  logic [DL_W-1:0]   head_dl_r, head_dl_nxt;
  logic [CNT_OUT_W-1:0] count_r, count_nxt;

  assign req_id       = in_tdata[TID_W-1:0];
  assign req_deadline = in_tdata[TID_W+DL_W-1:TID_W];
  assign req_now      = in_tdata[TID_W+2*DL_W-1:TID_W+DL_W];

  // output register frees the input whenever it is empty or being drained
  assign in_tready  = !out_valid_r || out_tready;
  assign req_accept = in_tvalid && in_tready;

  assign id_in_range = ({1'b0, req_id} < (TID_W + 1)'(TASK_COUNT));
  assign id_marked   = id_in_range && marks_r[req_id[MARK_IW-1:0]];
  assign is_full     = (cnt_r >= CNT_W'(QUEUE_DEPTH));
  assign head_due    = (cnt_r != '0) && (req_now >= cell_q[0].deadline);

  always_comb begin
    ins_ok   = 1'b0;
    ins_full = 1'b0;
    pop_ok   = 1'b0;
    rem_ok   = 1'b0;
    if (req_accept) begin
      case (in_tuser)
        MODE_INSERT: begin
          ins_ok   = id_in_range && !id_marked && !is_full;
          ins_full = id_in_range && !id_marked && is_full;
        end
        MODE_POLL: begin
          pop_ok = head_due;
        end
        MODE_REMOVE: begin
          rem_ok = id_in_range && cell_hit[QUEUE_DEPTH-1];
        end
        default: begin
          ins_ok = 1'b0;
        end
      endcase
    end
  end

  assign new_entry.deadline = req_deadline;
  assign new_entry.task_id  = req_id;

  assign ctl.do_insert = ins_ok;
  assign ctl.do_pop    = pop_ok;
  // cells shift left of the matching slot only when removal is legal
  assign ctl.do_remove = req_accept && (in_tuser == MODE_REMOVE) && id_in_range;

  // cell row: each cell sees its neighbors and the left-side compare results
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_q, right_q;
    logic   left_le, left_hit;

    if (g == 0) begin : g_first
      assign left_q   = new_entry;
      assign left_le  = 1'b1;
      assign left_hit = 1'b0;
    end else begin : g_inner
      assign left_q   = cell_q[g-1];
      assign left_le  = cell_le[g-1];
      assign left_hit = cell_hit[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_q = new_entry;
    end else begin : g_mid
      assign right_q = cell_q[g+1];
    end

    dstq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_entry (new_entry),
      .valid     (CNT_W'(g) < cnt_r),
      .left_q    (left_q),
      .right_q   (right_q),
      .left_le   (left_le),
      .left_hit  (left_hit),
      .q         (cell_q[g]),
      .q_nxt     (cell_q_nxt[g]),
      .le        (cell_le[g]),
      .hit       (cell_hit[g])
    );
  end

  // occupancy and queued-task marks
  always_comb begin
    cnt_nxt   = cnt_r;
    marks_nxt = marks_r;
    if (ins_ok) begin
      cnt_nxt = cnt_r + 1'b1;
      marks_nxt[req_id[MARK_IW-1:0]] = 1'b1;
    end else if (pop_ok) begin
      cnt_nxt = cnt_r - 1'b1;
      marks_nxt[cell_q[0].task_id[MARK_IW-1:0]] = 1'b0;
    end else if (rem_ok) begin
      cnt_nxt = cnt_r - 1'b1;
      marks_nxt[req_id[MARK_IW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      marks_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      marks_r <= marks_nxt;
    end
  end

  // result for the accepted request, head taken from the row's next state
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    success_nxt    = success_r;
    full_nxt       = full_r;
    head_valid_nxt = head_valid_r;
    popped_nxt     = popped_r;
    head_dl_nxt    = head_dl_r;
    count_nxt      = count_r;
    if (req_accept) begin
      out_valid_nxt  = 1'b1;
      success_nxt    = ins_ok || pop_ok || rem_ok;
      full_nxt       = ins_full;
      head_valid_nxt = (cnt_nxt != '0);
      popped_nxt     = pop_ok ? cell_q[0].task_id : '0;
      head_dl_nxt    = (cnt_nxt != '0) ? cell_q_nxt[0].deadline : '0;
      count_nxt      = CNT_OUT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    success_r    <= success_nxt;
    full_r       <= full_nxt;
    head_valid_r <= head_valid_nxt;
    popped_r     <= popped_nxt;
    head_dl_r    <= head_dl_nxt;
    count_r      <= count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - TID_W - DL_W - CNT_OUT_W)'(0),
                       count_r, head_dl_r, popped_r};
  assign out_tuser  = {head_valid_r, full_r, success_r};

  // occupancy never passes the row length
  `DSTQ_ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH))
  // one mark per queued task
  `DSTQ_ASSERT_IMPLIES(a_marks_match, clk, rst_n, 1'b1, $countones(marks_r) == int'(cnt_r))
  // head pair stays in deadline order
  `DSTQ_ASSERT_IMPLIES(a_head_order, clk, rst_n, cnt_r >= CNT_W'(2),
                       cell_q[0].deadline <= cell_q[1].deadline)
  // a taken insert grows the queue by one
  `DSTQ_ASSERT_NEXT(a_ins_grow, clk, rst_n, ins_ok, cnt_r == $past(cnt_r) + 1'b1)
  // a result is always registered right after a request is taken
  `DSTQ_ASSERT_NEXT(a_result_follows, clk, rst_n, req_accept, out_valid_r)

endmodule
